/* rtl/rrtp_pkg.sv */
// Shared types and constants for the round-robin task picker.
package rrtp_pkg;

   // Task states as stored in the run queue
   localparam logic [2:0] ST_NEW      = 3'd0;
   localparam logic [2:0] ST_READY    = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_BLOCKING = 3'd3;
   localparam logic [2:0] ST_SLEEPING = 3'd4;
   localparam logic [2:0] ST_LEAVING  = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_UNUSABLE = 2'd1;
   localparam logic [1:0] ERR_FULL     = 2'd2;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_QUANTUM_RELOAD = 1'b0;
   localparam logic CSR_SCHED_ENABLED  = 1'b1;

   localparam logic [7:0] QUANTUM_RESET = 8'd20;

   typedef enum logic [1:0] {
      FN_ADD     = 2'd0,
      FN_SET     = 2'd1,
      FN_TICK    = 2'd2,
      FN_RESCHED = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SET_SCAN,
      S_R_DEMOTE,
      S_R_PICK,
      S_R_SCAN,
      S_R_FRONT,
      S_R_SHIFT,
      S_FIN,
      S_OUT
   } fsm_state_type;

   typedef struct packed {
      logic [7:0] id;
      logic [2:0] state;
   } entry_type;

   typedef struct packed {
      logic [1:0] error_code;
      logic       on_idle;
      logic [7:0] current_task;
      logic       switched;
   } rsp_type;

endpackage

/* rtl/rrtp_queue_mem.sv */
// Run queue storage: one write port, one read port, registered read data.
module rrtp_queue_mem
   import rrtp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [IDX_W-1:0] waddr,
   input  entry_type        wdata,
   input  logic [IDX_W-1:0] raddr,
   output entry_type        rdata
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/rrtp_sched_fsm.sv */
// Sequencer: decodes requests, walks and compacts the run queue, builds results.
module rrtp_sched_fsm
   import rrtp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int IDX_W = $clog2(QUEUE_DEPTH),
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  func_type         req_func,
   input  logic [7:0]       req_task_id,
   input  logic [2:0]       req_new_state,
   input  logic [7:0]       quantum_reload,
   input  logic             sched_enabled,
   input  logic             rsp_free,
   output logic             rsp_load,
   output rsp_type          rsp_data,
   output logic             mem_we,
   output logic [IDX_W-1:0] mem_waddr,
   output entry_type        mem_wdata,
   output logic [IDX_W-1:0] mem_raddr,
   input  entry_type        mem_rdata
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

   fsm_state_type    state_ff, state_in;
   func_type         func_ff, func_in;
   logic [7:0]       id_ff, id_in;
   logic [2:0]       nst_ff, nst_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             idle_ff, idle_in;
   logic [7:0]       tick_ff, tick_in;
   logic             from_idle_ff, from_idle_in;
   logic             cur_gone_ff, cur_gone_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             sw_ff, sw_in;
   logic [1:0]       err_ff, err_in;

   logic             pick_hit;
   logic [CNT_W-1:0] pick_p;
   logic [CNT_W-1:0] cur_ext;
   logic             resched;

   assign cur_ext = CNT_W'(cur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cur_ff   <= '0;
         idle_ff  <= 1'b1;
         tick_ff  <= QUANTUM_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         idle_ff  <= idle_in;
         tick_ff  <= tick_in;
      end
      func_ff      <= func_in;
      id_ff        <= id_in;
      nst_ff       <= nst_in;
      from_idle_ff <= from_idle_in;
      cur_gone_ff  <= cur_gone_in;
      scan_ff      <= scan_in;
      ptr_ff       <= ptr_in;
      sw_ff        <= sw_in;
      err_ff       <= err_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      nst_in       = nst_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      idle_in      = idle_ff;
      tick_in      = tick_ff;
      from_idle_in = from_idle_ff;
      cur_gone_in  = cur_gone_ff;
      scan_in      = scan_ff;
      ptr_in       = ptr_ff;
      sw_in        = sw_ff;
      err_in       = err_ff;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = mem_rdata;
      mem_raddr    = cur_ff;
      pick_hit     = 1'b0;
      pick_p       = '0;
      resched      = 1'b0;

      rsp_data.switched     = sw_ff;
      rsp_data.on_idle      = idle_ff;
      rsp_data.error_code   = err_ff;
      rsp_data.current_task = (!idle_ff && (cur_ext < count_ff)) ? mem_rdata.id : 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in  = req_func;
               id_in    = req_task_id;
               nst_in   = req_new_state;
               sw_in    = 1'b0;
               err_in   = ERR_OK;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            unique case (func_ff)
               FN_ADD: begin
                  if (count_ff == DEPTH_CNT) begin
                     err_in = ERR_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IDX_W-1:0];
                     mem_wdata = '{id: id_ff, state: nst_ff};
                     count_in  = count_ff + ONE_CNT;
                  end
                  state_in = S_FIN;
               end
               FN_SET: begin
                  if (count_ff == '0) begin
                     err_in   = ERR_UNKNOWN;
                     state_in = S_FIN;
                  end else begin
                     mem_raddr = '0;
                     ptr_in    = '0;
                     state_in  = S_SET_SCAN;
                  end
               end
               FN_TICK: begin
                  if (tick_ff == 8'd0) begin
                     tick_in = quantum_reload;
                     resched = 1'b1;
                  end else begin
                     tick_in = tick_ff - 8'd1;
                  end
                  state_in = S_FIN;
               end
               default: begin
                  resched = 1'b1;
               end
            endcase
            if (resched) begin
               state_in = S_FIN;
               if (sched_enabled) begin
                  from_idle_in = idle_ff || (cur_ext >= count_ff);
                  cur_gone_in  = 1'b0;
                  scan_in      = cur_ext + ONE_CNT;
                  if (idle_ff || (cur_ext >= count_ff)) begin
                     state_in = S_R_PICK;
                  end else begin
                     mem_raddr = cur_ff;
                     state_in  = S_R_DEMOTE;
                  end
               end
            end
         end

         // Find the first entry with a matching id, one entry per cycle
         S_SET_SCAN: begin
            if (mem_rdata.id == id_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff[IDX_W-1:0];
               mem_wdata = '{id: id_ff, state: nst_ff};
               state_in  = S_FIN;
            end else if ((ptr_ff + ONE_CNT) < count_ff) begin
               ptr_in    = ptr_ff + ONE_CNT;
               mem_raddr = IDX_W'(ptr_ff + ONE_CNT);
            end else begin
               err_in   = ERR_UNKNOWN;
               state_in = S_FIN;
            end
         end

         S_R_DEMOTE: begin
            if (mem_rdata.state == ST_RUNNING) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = '{id: mem_rdata.id, state: ST_READY};
            end
            state_in = S_R_PICK;
         end

         S_R_PICK: begin
            if (count_ff == '0) begin
               idle_in  = 1'b1;
               sw_in    = 1'b1;
               state_in = S_FIN;
            end else if (!from_idle_ff && (scan_ff < count_ff)) begin
               mem_raddr = scan_ff[IDX_W-1:0];
               ptr_in    = scan_ff;
               state_in  = S_R_SCAN;
            end else begin
               mem_raddr = '0;
               state_in  = S_R_FRONT;
            end
         end

         S_R_SCAN: begin
            if (mem_rdata.state != ST_SLEEPING) begin
               pick_hit = 1'b1;
               pick_p   = ptr_ff;
            end else if ((ptr_ff + ONE_CNT) < count_ff) begin
               ptr_in    = ptr_ff + ONE_CNT;
               mem_raddr = IDX_W'(ptr_ff + ONE_CNT);
            end else begin
               mem_raddr = '0;
               state_in  = S_R_FRONT;
            end
         end

         S_R_FRONT: begin
            if (mem_rdata.state == ST_SLEEPING) begin
               idle_in  = 1'b1;
               sw_in    = 1'b1;
               state_in = S_FIN;
            end else begin
               pick_hit = 1'b1;
               pick_p   = '0;
            end
         end

         // Compaction: move entry ptr+1 down to ptr
         S_R_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[IDX_W-1:0];
            mem_wdata = mem_rdata;
            ptr_in    = ptr_ff + ONE_CNT;
            if ((ptr_ff + ONE_CNT) < count_ff) begin
               mem_raddr = IDX_W'(ptr_ff + TWO_CNT);
            end else begin
               state_in = S_R_PICK;
            end
         end

         S_FIN: begin
            state_in = S_OUT;
         end

         S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Judge the picked entry
      if (pick_hit) begin
         if ((mem_rdata.state == ST_NEW) || (mem_rdata.state == ST_READY)) begin
            mem_we    = 1'b1;
            mem_waddr = pick_p[IDX_W-1:0];
            mem_wdata = '{id: mem_rdata.id, state: ST_RUNNING};
            cur_in    = pick_p[IDX_W-1:0];
            idle_in   = 1'b0;
            sw_in     = 1'b1;
            state_in  = S_FIN;
         end else if (mem_rdata.state != ST_LEAVING) begin
            if (cur_gone_ff) begin
               idle_in = 1'b1;
            end
            err_in   = ERR_UNUSABLE;
            state_in = S_FIN;
         end else begin
            count_in = count_ff - ONE_CNT;
            if (pick_p < scan_ff) begin
               scan_in = scan_ff - ONE_CNT;
            end
            if (!from_idle_ff && !cur_gone_ff) begin
               if (pick_p < cur_ext) begin
                  cur_in = cur_ff - IDX_W'(1);
               end else if (pick_p == cur_ext) begin
                  cur_gone_in = 1'b1;
               end
            end
            ptr_in = pick_p;
            if ((pick_p + ONE_CNT) < count_ff) begin
               mem_raddr = IDX_W'(pick_p + ONE_CNT);
               state_in  = S_R_SHIFT;
            end else begin
               state_in = S_R_PICK;
            end
         end
      end
   end

endmodule

/* rtl/round_robin_task_picker_core.sv */
// Top level of the round-robin task picker: config registers, result register, core.
// Steps: a set-state scans the queue for its entry; a reschedule reads entries and removes
//   each leaving task it meets by moving the later entries down.
// Flow: one transaction at a time; the next is taken in the cycle after the result is loaded,
//   and a finished result waits in the output register meanwhile.
// Reset: synchronous, active high; queue empty, idle task current, tick count 20, scheduling
//   off. Queue memory contents are not cleared (entries are only read below the fill count).
module round_robin_task_picker_core
   import rrtp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request: func[1:0], task_id[9:2], new_state[12:10], zero [15:13]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Response: switched[0], current_task[8:1], on_idle[9], error_code[11:10], zero [15:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Config write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [7:0] quantum_ff, quantum_in;
   logic       enabled_ff, enabled_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic             rsp_free;
   logic             rsp_load;
   rsp_type          core_rsp;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;

   // Config registers: the user must write them only between transactions; nothing in the block enforces this.
   always_comb begin
      quantum_in = quantum_ff;
      enabled_in = enabled_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUANTUM_RELOAD: quantum_in = csr_wdata;
            CSR_SCHED_ENABLED:  enabled_in = csr_wdata[0];
            default:            quantum_in = quantum_ff;
         endcase
      end
   end

   // Output register: holds a result until taken, frees the core meanwhile
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quantum_ff   <= quantum_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   rrtp_sched_fsm #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_sched_fsm (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_func       (func_type'(req_tdata[1:0])),
      .req_task_id    (req_tdata[9:2]),
      .req_new_state  (req_tdata[12:10]),
      .quantum_reload (quantum_ff),
      .sched_enabled  (enabled_ff),
      .rsp_free       (rsp_free),
      .rsp_load       (rsp_load),
      .rsp_data       (core_rsp),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   rrtp_queue_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

/* rtl/rrtp_checker.sv */
// Port-level checks for the task picker, bound to the top level.
module rrtp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response transaction holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Idle task current means no task id reported
   a_idle_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:1] == 8'd0)
      else $error("task id reported while idle");

   // A completed switch carries no error
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[11:10] == 2'd0)
      else $error("switch reported with an error");

   // Ready for a request right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

endmodule

bind round_robin_task_picker_core rrtp_checker u_rrtp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
